// ----- rtl/ssl_pkg.sv -----
package ssl_pkg;

   // Channel count and field widths.
   localparam int CHANNELS_DEF = 6;
   localparam int PULSE_W      = 16;
   localparam int WIDTH_W      = 12;
   localparam int SLEW_W       = 8;
   localparam int DUTY_W       = 10;
   localparam int KIND_W       = 2;
   localparam int CSR_ADDR_W   = 2;
   localparam int PROD_W       = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_SLEW_LIMIT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_PULSE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_PULSE    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_PULSE    = 2'd3;

   // Reset values.
   localparam logic [SLEW_W-1:0]  RST_SLEW_LIMIT   = 8'd6;
   localparam logic [WIDTH_W-1:0] RST_CENTER_PULSE = 12'd1500;
   localparam logic [WIDTH_W-1:0] RST_MIN_PULSE    = 12'd500;
   localparam logic [WIDTH_W-1:0] RST_MAX_PULSE    = 12'd2500;
   localparam logic [WIDTH_W-1:0] RST_WIDTH        = 12'd1500;

   // Word kinds carried in the low tuser bit.
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Duty scale: floor(p * 4096 / 20000) = (p * 858994) >> 22 for any 12-bit p.
   localparam logic [19:0] DUTY_MULT  = 20'd858994;
   localparam int          DUTY_SHIFT = 22;

   typedef struct packed {
      logic [SLEW_W-1:0]  slew_limit;
      logic [WIDTH_W-1:0] center_pulse;
      logic [WIDTH_W-1:0] min_pulse;
      logic [WIDTH_W-1:0] max_pulse;
   } cfg_type;

   // Per-word strobes to the channel state, already qualified by the stage handoff.
   typedef struct packed {
      logic recenter;
      logic load;
      logic tick;
   } ctl_type;

endpackage

// ----- rtl/ssl_channel.sv -----
module ssl_channel (
   input  logic                        clock,
   input  logic                        reset,
   input  ssl_pkg::ctl_type            ctl,
   input  ssl_pkg::cfg_type            cfg,
   input  logic [ssl_pkg::PULSE_W-1:0] pulse,
   output logic [ssl_pkg::WIDTH_W-1:0] width_next,
   output logic                        moving
);
   import ssl_pkg::*;

   logic [WIDTH_W-1:0] cur_ff, cur_in;
   logic [WIDTH_W-1:0] tgt_ff, tgt_in;
   logic [SLEW_W-1:0]  lim;
   logic               up;
   logic [WIDTH_W-1:0] gap;
   logic [WIDTH_W-1:0] step;
   logic [WIDTH_W-1:0] slewed;
   logic               in_range;

   // A slew limit of zero still moves by one.
   assign lim = (cfg.slew_limit == '0) ? SLEW_W'(1) : cfg.slew_limit;

   // Step toward the target by at most the limit.
   always_comb begin
      up     = tgt_ff > cur_ff;
      gap    = up ? (tgt_ff - cur_ff) : (cur_ff - tgt_ff);
      step   = (gap > WIDTH_W'(lim)) ? WIDTH_W'(lim) : gap;
      slewed = up ? (cur_ff + step) : (cur_ff - step);
   end

   assign moving   = tgt_ff != cur_ff;
   assign in_range = (pulse >= PULSE_W'(cfg.min_pulse)) && (pulse <= PULSE_W'(cfg.max_pulse));

   // Next current and target widths.
   always_comb begin
      cur_in = cur_ff;
      tgt_in = tgt_ff;
      if (ctl.recenter) begin
         cur_in = cfg.center_pulse;
         tgt_in = cfg.center_pulse;
      end else if (ctl.load) begin
         if (in_range) begin
            tgt_in = pulse[WIDTH_W-1:0];
         end
      end else if (ctl.tick) begin
         cur_in = slewed;
      end
   end

   assign width_next = cur_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= RST_WIDTH;
         tgt_ff <= RST_WIDTH;
      end else begin
         cur_ff <= cur_in;
         tgt_ff <= tgt_in;
      end
   end

endmodule

// ----- rtl/ssl_duty.sv -----
module ssl_duty #(
   parameter int CHANNELS = ssl_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ssl_pkg::WIDTH_W-1:0] in_width [CHANNELS],
   input  logic [ssl_pkg::WIDTH_W-1:0] min_pulse,
   input  logic [ssl_pkg::WIDTH_W-1:0] max_pulse,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ssl_pkg::DUTY_W-1:0]  out_duty [CHANNELS]
);
   import ssl_pkg::*;

   logic               s2_valid_ff, s2_valid_in;
   logic [WIDTH_W-1:0] s2_width_ff [CHANNELS];
   logic               out_valid_ff, out_valid_in;
   logic [DUTY_W-1:0]  duty_ff [CHANNELS];
   logic [DUTY_W-1:0]  duty_in [CHANNELS];
   logic [WIDTH_W-1:0] clamped [CHANNELS];
   logic [PROD_W-1:0]  prod [CHANNELS];
   logic               out_stage_ready;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign in_ready        = !s2_valid_ff || out_stage_ready;

   // Clamp to the pulse limits, then scale by a reciprocal multiply.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (s2_width_ff[i] < min_pulse) begin
            clamped[i] = min_pulse;
         end else if (s2_width_ff[i] > max_pulse) begin
            clamped[i] = max_pulse;
         end else begin
            clamped[i] = s2_width_ff[i];
         end
         prod[i]    = PROD_W'(clamped[i]) * PROD_W'(DUTY_MULT);
         duty_in[i] = prod[i][DUTY_SHIFT +: DUTY_W];
      end
   end

   always_comb begin
      s2_valid_in  = in_ready ? in_valid : s2_valid_ff;
      out_valid_in = out_stage_ready ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Width snapshot and result word.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_width_ff <= in_width;
      end
      if (s2_valid_ff && out_stage_ready) begin
         duty_ff <= duty_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_duty  = duty_ff;

endmodule

// ----- rtl/six_channel_servo_slew_limiter.sv -----
// Slew-rate limiter for a bank of servo channels.
// Each req_ word is either a command packet (req_tuser[0] = 0) or a motion
// tick (req_tuser[0] = 1). A packet with req_tuser[1] set recenters every
// channel and returns one rsp_ word; otherwise each in-range pulse in
// req_tdata becomes that channel's target and no word is returned. A tick
// moves every current width toward its target by at most the slew limit and
// returns one rsp_ word when any channel moved.
// Each rsp_ word carries the clamped, scaled PWM duty of every channel.
// A result reaches rsp_ through the input register, the state update with
// width snapshot, then the clamp and scale register. Throughput: one word
// per cycle while rsp_ does not stall; the per-channel state update is a
// single compare, subtract and add between input register and the state.
// The csr_ port is always ready and must be written only while no word is
// in flight; the block itself does not enforce this. Reset clears all
// stages, recenters every channel to 1500 us and restores the register
// defaults. When rsp_tready is low the result holds, the two internal stages
// fill, and req_tready drops once they are full.
module six_channel_servo_slew_limiter #(
   parameter int CHANNELS = ssl_pkg::CHANNELS_DEF,
   localparam int RSP_W = ((CHANNELS * ssl_pkg::DUTY_W + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pulse_0, pulse_1, ... (16 bits each)
   input  logic [CHANNELS*ssl_pkg::PULSE_W-1:0] req_tdata,
   // op, reset_cmd
   input  logic [ssl_pkg::KIND_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // duty_0, duty_1, ... (10 bits each), zero fill to a byte
   output logic [RSP_W-1:0]                     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssl_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [ssl_pkg::WIDTH_W-1:0]          csr_data
);
   import ssl_pkg::*;

   cfg_type                    cfg_ff, cfg_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]          s1_kind_ff;
   logic [CHANNELS*PULSE_W-1:0] s1_pulse_ff;
   logic                       s1_fire;
   logic                       duty_ready;
   ctl_type                    ctl;
   logic                       emit;
   logic [CHANNELS-1:0]        moving;
   logic [WIDTH_W-1:0]         width_next [CHANNELS];
   logic [DUTY_W-1:0]          duty [CHANNELS];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SLEW_LIMIT:   cfg_in.slew_limit   = csr_data[SLEW_W-1:0];
            REG_CENTER_PULSE: cfg_in.center_pulse = csr_data;
            REG_MIN_PULSE:    cfg_in.min_pulse    = csr_data;
            REG_MAX_PULSE:    cfg_in.max_pulse    = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_limit   <= RST_SLEW_LIMIT;
         cfg_ff.center_pulse <= RST_CENTER_PULSE;
         cfg_ff.min_pulse    <= RST_MIN_PULSE;
         cfg_ff.max_pulse    <= RST_MAX_PULSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register.
   assign s1_fire     = s1_valid_ff && duty_ready;
   assign req_tready  = !s1_valid_ff || duty_ready;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff  <= req_tuser;
         s1_pulse_ff <= req_tdata;
      end
   end

   // Decode the word kind into state strobes.
   always_comb begin
      ctl.recenter = s1_fire && (s1_kind_ff[0] == OP_PACKET) && s1_kind_ff[1];
      ctl.load     = s1_fire && (s1_kind_ff[0] == OP_PACKET) && !s1_kind_ff[1];
      ctl.tick     = s1_fire && (s1_kind_ff[0] == OP_TICK);
      emit         = ctl.recenter || (ctl.tick && (|moving));
   end

   // Per-channel width state.
   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      ssl_channel u_chan (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cfg        (cfg_ff),
         .pulse      (s1_pulse_ff[i*PULSE_W +: PULSE_W]),
         .width_next (width_next[i]),
         .moving     (moving[i])
      );
   end

   // Clamp, scale and result register.
   ssl_duty #(
      .CHANNELS (CHANNELS)
   ) u_duty (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit),
      .in_ready  (duty_ready),
      .in_width  (width_next),
      .min_pulse (cfg_ff.min_pulse),
      .max_pulse (cfg_ff.max_pulse),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_duty  (duty)
   );

   // Pack the result word.
   for (genvar i = 0; i < CHANNELS; i++) begin : g_pack
      assign rsp_tdata[i*DUTY_W +: DUTY_W] = duty[i];
   end
   if (RSP_W > CHANNELS * DUTY_W) begin : g_fill
      assign rsp_tdata[RSP_W-1:CHANNELS*DUTY_W] = '0;
   end

endmodule

// ----- bench/six_channel_servo_slew_limiter_test.sv -----
`timescale 1ns / 100ps

module six_channel_servo_slew_limiter_test;
   import ssl_pkg::*;

   localparam int NCH         = 6;
   localparam int RSP_BITS    = ((NCH * DUTY_W + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_WORDS = 222;
   localparam int SETTLE_CYCLES = 8;

   // Meaning of the reset_cmd flag on a command packet.
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_RECENTER = 1'b1;

   typedef logic [0:NCH-1][PULSE_W-1:0] pulse_set_type;
   typedef logic [0:NCH-1][DUTY_W-1:0]  duty_row_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FLAT} check_kind_type;
   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    op;
      logic                    rc;
      pulse_set_type           pulses;
      logic [CSR_ADDR_W-1:0]   reg_idx;
      logic [WIDTH_W-1:0]      reg_val;
      check_kind_type          chk;
      logic [DUTY_W-1:0]       flat;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [NCH*PULSE_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [WIDTH_W-1:0]    csr_data = '0;

   // Predicted channel state and register copy.
   logic [WIDTH_W-1:0] cur_w [NCH];
   logic [WIDTH_W-1:0] tgt_w [NCH];
   cfg_type            cfg;

   duty_row_type  duty_q [$];
   plan_row_type  plan [$];
   logic        calm = 1'b0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   int          words_sent = 0;
   int          duties_seen = 0;
   int          regs_written = 0;
   int          mismatches = 0;

   six_channel_servo_slew_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Clamp a width to the limits and scale it to a PWM on-count out of 4096.
   function automatic logic [DUTY_W-1:0] scaled_duty(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] p;
      logic [31:0]        prod;
      p = w;
      if (p < cfg.min_pulse) begin
         p = cfg.min_pulse;
      end else if (p > cfg.max_pulse) begin
         p = cfg.max_pulse;
      end
      prod = ({20'd0, p} * 32'd4096) / 32'd20000;
      return prod[DUTY_W-1:0];
   endfunction

   function automatic void apply_reg(input logic [CSR_ADDR_W-1:0] idx,
                                     input logic [WIDTH_W-1:0] val);
      case (idx)
         REG_SLEW_LIMIT: begin
            cfg.slew_limit = val[SLEW_W-1:0];
         end
         REG_CENTER_PULSE: begin
            cfg.center_pulse = val;
         end
         REG_MIN_PULSE: begin
            cfg.min_pulse = val;
         end
         REG_MAX_PULSE: begin
            cfg.max_pulse = val;
         end
         default: begin
         end
      endcase
   endfunction

   // Advance the predicted servo state by one word; returns 1 when a duty word is due.
   function automatic logic servo_step(input logic op, input logic rc, input pulse_set_type p,
                                       output duty_row_type duty);
      int   lim;
      int   diff;
      int   stepv;
      int   nx;
      logic emits;
      emits = 1'b0;
      if (op == OP_PACKET) begin
         if (rc == CMD_RECENTER) begin
            for (int ch = 0; ch < NCH; ch++) begin
               cur_w[ch] = cfg.center_pulse;
               tgt_w[ch] = cfg.center_pulse;
            end
            emits = 1'b1;
         end else begin
            for (int ch = 0; ch < NCH; ch++) begin
               if (p[ch] >= cfg.min_pulse && p[ch] <= cfg.max_pulse) begin
                  tgt_w[ch] = p[ch][WIDTH_W-1:0];
               end
            end
         end
      end else begin
         // A slew of zero still moves by one.
         lim = (cfg.slew_limit == 0) ? 1 : int'(cfg.slew_limit);
         for (int ch = 0; ch < NCH; ch++) begin
            diff = int'(tgt_w[ch]) - int'(cur_w[ch]);
            if (diff != 0) begin
               stepv = diff;
               if (stepv > lim) stepv = lim;
               if (stepv < -lim) stepv = -lim;
               nx = int'(cur_w[ch]) + stepv;
               cur_w[ch] = nx[WIDTH_W-1:0];
               emits = 1'b1;
            end
         end
      end
      for (int ch = 0; ch < NCH; ch++) begin
         duty[ch] = scaled_duty(cur_w[ch]);
      end
      return emits;
   endfunction

   function automatic plan_row_type word_row(input logic op, input logic rc,
                                             input pulse_set_type p,
                                             input check_kind_type chk,
                                             input logic [DUTY_W-1:0] flat);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.op = op;
      r.rc = rc;
      r.pulses = p;
      r.chk = chk;
      r.flat = flat;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_ADDR_W-1:0] idx,
                                            input logic [WIDTH_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.kind = ROW_REG;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   // A requested width: mostly inside the limits, sometimes on or just past them.
   function automatic logic [PULSE_W-1:0] pick_pulse();
      logic [PULSE_W-1:0] lo;
      logic [PULSE_W-1:0] hi;
      lo = {4'd0, cfg.min_pulse};
      hi = {4'd0, cfg.max_pulse};
      case ($urandom_range(0, 9))
         0: return PULSE_W'($urandom);
         1: return lo;
         2: return hi;
         3: return lo - 1'b1;
         4: return hi + 1'b1;
         default: begin
            if (lo <= hi) begin
               return PULSE_W'($urandom_range(lo, hi));
            end
            return PULSE_W'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   // Offer one word, wait for it to be taken and record what it should produce.
   task automatic send_word(input logic op, input logic rc, input pulse_set_type p,
                            input check_kind_type chk, input logic [DUTY_W-1:0] flat);
      logic [NCH*PULSE_W-1:0] packed_p;
      duty_row_type           duty;
      logic                   emits;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      for (int ch = 0; ch < NCH; ch++) begin
         packed_p[ch*PULSE_W +: PULSE_W] = p[ch];
      end
      req_tvalid <= 1'b1;
      req_tdata <= packed_p;
      req_tuser <= {rc, op};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      emits = servo_step(op, rc, p, duty);
      case (chk)
         CHK_MODEL: begin
            if (emits) duty_q.push_back(duty);
         end
         CHK_FLAT: begin
            duty_q.push_back({NCH{flat}});
         end
         default: begin
         end
      endcase
   endtask

   // Stop offering words and let the pipeline empty before a register write.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (duty_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [WIDTH_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      regs_written++;
   endtask

   task automatic program_regs(input logic [WIDTH_W-1:0] slew, input logic [WIDTH_W-1:0] center,
                               input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
      settle();
      write_reg(REG_SLEW_LIMIT, slew);
      write_reg(REG_CENTER_PULSE, center);
      write_reg(REG_MIN_PULSE, lo);
      write_reg(REG_MAX_PULSE, hi);
      csr_valid <= 1'b0;
   endtask

   // Result side stalls in random bursts, except in the calm final phase.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && !reset && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each duty word with the oldest expectation.
   always @(posedge clock) begin
      duty_row_type want;
      logic [DUTY_W-1:0] seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         duties_seen++;
         if (duty_q.size() == 0) begin
            flag_mismatch($sformatf("duty word %h with nothing expected", rsp_tdata));
         end else begin
            want = duty_q.pop_front();
            for (int ch = 0; ch < NCH; ch++) begin
               seen = rsp_tdata[ch*DUTY_W +: DUTY_W];
               if (seen !== want[ch]) begin
                  flag_mismatch($sformatf("duty_%0d got %0d, want %0d", ch, seen, want[ch]));
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d duty words outstanding",
                  QUIET_LIMIT, duty_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      pulse_set_type p;
      logic         op;
      logic         rc;
      int           r;
      logic [WIDTH_W-1:0] ph_slew [6];
      logic [WIDTH_W-1:0] ph_center [6];
      logic [WIDTH_W-1:0] ph_lo [6];
      logic [WIDTH_W-1:0] ph_hi [6];

      cfg.slew_limit = RST_SLEW_LIMIT;
      cfg.center_pulse = RST_CENTER_PULSE;
      cfg.min_pulse = RST_MIN_PULSE;
      cfg.max_pulse = RST_MAX_PULSE;
      for (int ch = 0; ch < NCH; ch++) begin
         cur_w[ch] = RST_WIDTH;
         tgt_w[ch] = RST_WIDTH;
      end

      // Directed plan: reset state, field extremes, slew of zero, crossed limits.
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, '0, CHK_FLAT, 10'd307));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_NONE, '0));
      plan.push_back(word_row(OP_PACKET, CMD_LOAD,
         {16'd0, 16'd65535, 16'd499, 16'd2501, 16'd500, 16'd2500}, CHK_NONE, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(word_row(OP_TICK, CMD_RECENTER, {NCH{16'hFFFF}}, CHK_MODEL, '0));
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, {NCH{16'hFFFF}}, CHK_FLAT, 10'd307));
      plan.push_back(reg_row(REG_SLEW_LIMIT, 12'd0));
      plan.push_back(reg_row(REG_CENTER_PULSE, 12'd4095));
      plan.push_back(reg_row(REG_MIN_PULSE, 12'd0));
      plan.push_back(reg_row(REG_MAX_PULSE, 12'd4095));
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, '0, CHK_FLAT, 10'd838));
      plan.push_back(word_row(OP_PACKET, CMD_LOAD,
         {16'd0, 16'd4095, 16'd4096, 16'd65535, 16'd1, 16'd2048}, CHK_NONE, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(reg_row(REG_SLEW_LIMIT, 12'd255));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(reg_row(REG_MIN_PULSE, 12'd3000));
      plan.push_back(reg_row(REG_MAX_PULSE, 12'd1000));
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, '0, CHK_FLAT, 10'd204));
      plan.push_back(word_row(OP_PACKET, CMD_LOAD,
         {16'd3000, 16'd1000, 16'd2000, 16'd0, 16'd4095, 16'd65535}, CHK_NONE, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_NONE, '0));
      plan.push_back(reg_row(REG_CENTER_PULSE, 12'd0));
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, '0, CHK_MODEL, '0));
      plan.push_back(reg_row(REG_SLEW_LIMIT, 12'd6));
      plan.push_back(reg_row(REG_CENTER_PULSE, 12'd1500));
      plan.push_back(reg_row(REG_MIN_PULSE, 12'd500));
      plan.push_back(reg_row(REG_MAX_PULSE, 12'd2500));
      plan.push_back(word_row(OP_PACKET, CMD_RECENTER, '0, CHK_FLAT, 10'd307));
      plan.push_back(word_row(OP_PACKET, CMD_LOAD,
         {16'd2500, 16'd500, 16'd1000, 16'd2000, 16'd1501, 16'd1499}, CHK_NONE, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));
      plan.push_back(word_row(OP_TICK, CMD_LOAD, '0, CHK_MODEL, '0));

      // Register settings for the random phases; the last one runs without stalls.
      ph_slew[0] = 12'd6;    ph_center[0] = 12'd1500; ph_lo[0] = 12'd500;  ph_hi[0] = 12'd2500;
      ph_slew[1] = 12'd255;  ph_center[1] = 12'd2048; ph_lo[1] = 12'd0;    ph_hi[1] = 12'd4095;
      ph_slew[2] = 12'd1;    ph_center[2] = 12'd500;  ph_lo[2] = 12'd500;  ph_hi[2] = 12'd2500;
      ph_slew[3] = 12'($urandom_range(0, 4095));
      ph_center[3] = 12'($urandom_range(0, 4095));
      ph_lo[3] = 12'($urandom_range(0, 2000));
      ph_hi[3] = 12'($urandom_range(2000, 4095));
      ph_slew[4] = 12'($urandom_range(0, 4095));
      ph_center[4] = 12'($urandom_range(0, 4095));
      ph_lo[4] = 12'd2600;   ph_hi[4] = 12'd400;
      ph_slew[5] = 12'hF28;  ph_center[5] = 12'd1500; ph_lo[5] = 12'd1000; ph_hi[5] = 12'd2000;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan; register rows wait for the pipeline to empty first.
      for (int k = 0; k < plan.size(); k++) begin
         if (plan[k].kind == ROW_REG) begin
            if (k == 0 || plan[k-1].kind != ROW_REG) settle();
            write_reg(plan[k].reg_idx, plan[k].reg_val);
            if (k == plan.size() - 1 || plan[k+1].kind != ROW_REG) csr_valid <= 1'b0;
         end else begin
            send_word(plan[k].op, plan[k].rc, plan[k].pulses, plan[k].chk, plan[k].flat);
         end
      end

      // Random phases: mostly target loads and ticks, some recenters and junk widths.
      for (int ph = 0; ph < 6; ph++) begin
         program_regs(ph_slew[ph], ph_center[ph], ph_lo[ph], ph_hi[ph]);
         if (ph == 5) calm = 1'b1;
         repeat (PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            for (int ch = 0; ch < NCH; ch++) begin
               p[ch] = PULSE_W'($urandom);
            end
            if (r < 6) begin
               op = OP_PACKET;
               rc = CMD_RECENTER;
            end else if (r < 40) begin
               op = OP_PACKET;
               rc = CMD_LOAD;
               for (int ch = 0; ch < NCH; ch++) begin
                  p[ch] = pick_pulse();
               end
            end else begin
               op = OP_TICK;
               rc = 1'($urandom_range(0, 1));
            end
            send_word(op, rc, p, CHK_MODEL, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (duty_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (duty_q.size() != 0) flag_mismatch("duty words still expected at the end");

      $display("covered %0d request words and %0d duty words over six register settings",
               words_sent, duties_seen);
      $display("%0d register writes, %0d mismatches", regs_written, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- six_channel_servo_slew_limiter.f -----
rtl/ssl_pkg.sv
rtl/ssl_channel.sv
rtl/ssl_duty.sv
rtl/six_channel_servo_slew_limiter.sv
bench/six_channel_servo_slew_limiter_test.sv
